>>> design/assert_macros.svh
// Assertion helpers for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MM_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the modular multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

  // Field width on the ports and working width of the arithmetic.
  localparam int unsigned FIELD_W       = 64;
  localparam int unsigned OPERAND_WIDTH = 64;
  localparam int unsigned CNT_W         = $clog2(2 * OPERAND_WIDTH);

  typedef struct packed {
    logic [FIELD_W-1:0] multiplicand;
    logic [FIELD_W-1:0] multiplier;
    logic [FIELD_W-1:0] modulus;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] remainder;
    logic               zero_modulus;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic mul_step;
    logic red_step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic zero_mod;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_RED  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

>>> design/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl
// Sequencer: multiply phase, reduction phase, one-cycle result strobe.
// ----------------------------------------------------------------------------
module mm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mm_pkg::status_t   status_i,
  output mm_pkg::cmd_t      cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  mm_pkg::state_e state_q, state_d;
  logic [mm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic accept;

  localparam logic [mm_pkg::CNT_W-1:0] MulLast = mm_pkg::CNT_W'(mm_pkg::OPERAND_WIDTH - 1);
  localparam logic [mm_pkg::CNT_W-1:0] RedLast =
    mm_pkg::CNT_W'(2 * mm_pkg::OPERAND_WIDTH - 1);

  assign busy_o = (state_q == mm_pkg::ST_MUL) || (state_q == mm_pkg::ST_RED);
  assign done_o = (state_q == mm_pkg::ST_DONE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o.load     = 1'b0;
    cmd_o.mul_step = 1'b0;
    cmd_o.red_step = 1'b0;
    case (state_q)
      mm_pkg::ST_IDLE, mm_pkg::ST_DONE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          // zero modulus skips both phases
          state_d    = status_i.zero_mod ? mm_pkg::ST_DONE : mm_pkg::ST_MUL;
        end else begin
          state_d = mm_pkg::ST_IDLE;
        end
      end
      mm_pkg::ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == MulLast) begin
          cnt_d   = '0;
          state_d = mm_pkg::ST_RED;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mm_pkg::ST_RED: begin
        cmd_o.red_step = 1'b1;
        if (cnt_q == RedLast) begin
          cnt_d   = '0;
          state_d = mm_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = mm_pkg::ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> design/mm_datapath.sv
// ----------------------------------------------------------------------------
// mm_datapath
// Operand registers, product shift register, remainder register and one
// shared adder used by both the shift-add multiply and the reduction.
// ----------------------------------------------------------------------------
module mm_datapath (
  input  logic            clk_i,
  input  mm_pkg::req_t    req_i,
  input  mm_pkg::cmd_t    cmd_i,
  output mm_pkg::status_t status_o,
  output mm_pkg::rsp_t    rsp_o
);

  localparam int unsigned W = mm_pkg::OPERAND_WIDTH;

  logic [W-1:0]   a_q;
  logic [W-1:0]   m_q;
  logic [W-1:0]   r_q;
  logic [2*W-1:0] prod_q;
  logic           zero_q;

  logic [W+1:0] op_a, op_b, sum;
  logic         cin;

  assign status_o.zero_mod = (req_i.modulus[W-1:0] == '0);

  // Multiply: high half plus multiplicand when the low bit is set.
  // Reduce: {r, next product bit} minus modulus; sign bit flags a borrow.
  always_comb begin
    if (cmd_i.red_step) begin
      op_a = {1'b0, r_q, prod_q[2*W-1]};
      op_b = ~{2'b00, m_q};
      cin  = 1'b1;
    end else begin
      op_a = {2'b00, prod_q[2*W-1:W]};
      op_b = prod_q[0] ? {2'b00, a_q} : '0;
      cin  = 1'b0;
    end
  end

  assign sum = op_a + op_b + (W+2)'(cin);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= req_i.multiplicand[W-1:0];
      m_q    <= req_i.modulus[W-1:0];
      prod_q <= {{W{1'b0}}, req_i.multiplier[W-1:0]};
      r_q    <= '0;
      zero_q <= status_o.zero_mod;
    end else if (cmd_i.mul_step) begin
      prod_q <= {sum[W:0], prod_q[W-1:1]};
    end else if (cmd_i.red_step) begin
      prod_q <= {prod_q[2*W-2:0], 1'b0};
      // keep the shifted value on borrow, else take the difference
      r_q    <= sum[W+1] ? op_a[W-1:0] : sum[W-1:0];
    end
  end

  assign rsp_o.remainder    = mm_pkg::FIELD_W'(r_q);
  assign rsp_o.zero_modulus = zero_q;

endmodule

>>> design/modular_multiply.sv
// ----------------------------------------------------------------------------
// modular_multiply
// Exact (multiplicand * multiplier) mod modulus with a controller and a
// shared-adder datapath.
//
//   beat      dir  handshake          payload
//   request   in   start_i / busy_o   req_i  (mm_pkg::req_t)
//   response  out  done_o             rsp_o  (mm_pkg::rsp_t)
//
// A request is taken when start_i is high and busy_o is low. The result
// shows on rsp_o for one cycle with done_o, after 64 shift-add steps
// and then 128 reduction steps through the one adder; a zero modulus
// strobes in the next cycle. A new request may be taken in the strobe
// cycle. The receiver cannot stall. Reset idles the controller.
// ----------------------------------------------------------------------------
module modular_multiply (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  mm_pkg::req_t req_i,
  output logic         busy_o,
  output logic         done_o,
  output mm_pkg::rsp_t rsp_o
);

  mm_pkg::cmd_t    cmd;
  mm_pkg::status_t status;

  mm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  mm_datapath u_datapath (
    .clk_i    (clk_i),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (rsp_o)
  );

endmodule

>>> design/mm_checker.sv
// ----------------------------------------------------------------------------
// mm_checker
// Port-level checks of the modular multiply block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         start_i,
  input mm_pkg::req_t req_i,
  input logic         busy_o,
  input logic         done_o,
  input mm_pkg::rsp_t rsp_o
);

  logic accept, zero_in;

  assign accept  = start_i && !busy_o;
  assign zero_in = (req_i.modulus[mm_pkg::OPERAND_WIDTH-1:0] == '0);

  `MM_ASSERT(a_done_not_busy, clk_i, rst_ni, done_o, !busy_o)
  `MM_ASSERT_NEXT(a_zero_fast, clk_i, rst_ni, accept && zero_in, done_o && rsp_o.zero_modulus)
  `MM_ASSERT_NEXT(a_work_busy, clk_i, rst_ni, accept && !zero_in, busy_o && !done_o)
  `MM_ASSERT(a_zero_rem, clk_i, rst_ni, done_o && rsp_o.zero_modulus, rsp_o.remainder == '0)

endmodule

bind modular_multiply mm_checker u_mm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

>>> tb/modular_multiply_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_multiply_test
// Self-checking bench for the modular multiply block. Requests are fed from
// a queue by a clocked driver; a clocked monitor predicts the remainder of
// every accepted request and checks each strobed result against the oldest
// prediction. Directed corner cases come first, then three random phases
// with different request gaps.
// ----------------------------------------------------------------------------
module modular_multiply_test;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};
  localparam logic [63:0] TOP_BIT  = {1'b1, 63'b0};

  logic         clk_i  = 1'b0;
  logic         rst_ni = 1'b0;
  logic         start_i = 1'b0;
  mm_pkg::req_t req_i = '0;
  logic         busy_o;
  logic         done_o;
  mm_pkg::rsp_t rsp_o;

  mm_pkg::req_t pending_reqs[$];
  mm_pkg::rsp_t remainders_due[$];
  logic         beat_taken = 1'b0;
  int unsigned  send_gap_pct = 10;
  int unsigned  reqs_queued = 0;
  int unsigned  reqs_taken = 0;
  int unsigned  mismatch_count = 0;

  modular_multiply u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // (a * b) mod m over the operand width; a zero modulus flags an error.
  function automatic mm_pkg::rsp_t mod_product(mm_pkg::req_t r);
    logic [63:0]  mask;
    logic [127:0] prod;
    logic [127:0] rem;
    mm_pkg::rsp_t res;
    mask = ALL_ONES >> (64 - mm_pkg::OPERAND_WIDTH);
    res  = '0;
    if ((r.modulus & mask) == 64'd0) begin
      res.zero_modulus = 1'b1;
    end else begin
      prod = {64'd0, r.multiplicand & mask} * {64'd0, r.multiplier & mask};
      rem  = prod % {64'd0, r.modulus & mask};
      res.remainder = rem[63:0];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_req(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    mm_pkg::req_t r;
    r.multiplicand = a;
    r.multiplier   = b;
    r.modulus      = m;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic queue_random_req();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    int unsigned kind;
    kind = $urandom_range(9, 0);
    a = rand_word();
    b = rand_word();
    m = rand_word();
    case (kind)
      5: begin
        // narrow operands
        a = a & 64'hFF;
        b = b & 64'hFF;
        m = (m & 64'hFF) | 64'd1;
      end
      6: m = m | TOP_BIT;
      7: begin
        if ($urandom_range(1, 0) == 0) m = 64'd0;
        else m = m & 64'hFFFF;
      end
      8: begin
        // product fits the operand width, modulus has its top bit set
        a = a & 64'hFFFF_FFFF;
        b = b & 64'hFFFF_FFFF;
        m = m | TOP_BIT;
      end
      9: begin
        // modulus at or next to the product, or equal to one factor
        a = a & 64'hFFFF_FFFF;
        b = b & 64'hFFFF_FFFF;
        case ($urandom_range(2, 0))
          0: m = a * b;
          1: m = a * b + 64'd1;
          default: m = a;
        endcase
      end
      default: ;
    endcase
    queue_req(a, b, m);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Wait until every queued request was taken and every result came back.
  task automatic wait_drained();
    while (reqs_taken != reqs_queued || remainders_due.size() != 0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  // Driver: hold a request until its beat is taken, then offer the next one.
  always @(negedge clk_i) begin
    mm_pkg::req_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || beat_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
        nxt = pending_reqs.pop_front();
        req_i   <= nxt;
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: predict on each accepted beat, check each strobed result.
  always @(posedge clk_i) begin
    mm_pkg::rsp_t want;
    beat_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        remainders_due.push_back(mod_product(req_i));
        reqs_taken++;
      end
      if (done_o) begin
        if (remainders_due.size() == 0) begin
          report_mismatch("unexpected result", rsp_o.remainder, 64'd0);
        end else begin
          want = remainders_due.pop_front();
          if (rsp_o.remainder !== want.remainder)
            report_mismatch("remainder", rsp_o.remainder, want.remainder);
          if (rsp_o.zero_modulus !== want.zero_modulus)
            report_mismatch("zero_modulus", 64'(rsp_o.zero_modulus),
                            64'(want.zero_modulus));
        end
      end
    end
  end

  initial begin
    // corner cases: extremes, zero modulus, product below or equal to modulus
    queue_req(64'd0, 64'd0, 64'd1);
    queue_req(64'd0, ALL_ONES, ALL_ONES);
    queue_req(ALL_ONES, ALL_ONES, ALL_ONES);
    queue_req(ALL_ONES, ALL_ONES, 64'd1);
    queue_req(ALL_ONES, ALL_ONES, ALL_ONES - 64'd1);
    queue_req(ALL_ONES, ALL_ONES, TOP_BIT);
    queue_req(ALL_ONES, ALL_ONES, TOP_BIT | 64'd1);
    queue_req(64'd1, 64'd1, ALL_ONES);
    queue_req(64'd3, 64'd5, 64'd100);
    queue_req(64'd6, 64'd7, 64'd42);
    queue_req(64'd6, 64'd7, 64'd41);
    queue_req(ALL_ONES, ALL_ONES, 64'd0);
    queue_req(64'd0, 64'd0, 64'd0);
    queue_req(64'd12345, 64'd678, 64'd0);
    queue_req(TOP_BIT, 64'd2, TOP_BIT);
    queue_req(TOP_BIT, TOP_BIT, 64'd3);
    queue_req(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_0000_0001);
    queue_req(64'd1, ALL_ONES - 64'd1, ALL_ONES);
    queue_req(ALL_ONES, 64'd1, ALL_ONES);
    queue_req(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // light request gaps
    repeat (290) queue_random_req();
    wait_drained();
    // heavy request gaps
    send_gap_pct = 68;
    repeat (300) queue_random_req();
    wait_drained();
    // back to back
    send_gap_pct = 0;
    repeat (300) queue_random_req();
    wait_drained();

    // catch any stray strobe
    repeat (250) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
